FILE: hw/rtl/fbdf_pkg.sv
// ----------------------------------------------------------------------------
// fbdf_pkg
// Shared types and constants for the frame deframer: header and command
// codes, parser phase codes and the result beat layout.
// ----------------------------------------------------------------------------
package fbdf_pkg;

    // header bytes and special codes
    localparam logic [7:0] HDR_BYTE0    = 8'h1E;
    localparam logic [7:0] HDR_BYTE1    = 8'h0C;
    localparam logic [7:0] HDR_BYTE2    = 8'h00;
    localparam logic [7:0] CMD_ACK      = 8'h7F;
    localparam logic [7:0] NUL_BYTE     = 8'h00;
    localparam logic [7:0] NUL_SUBST    = 8'h2E;
    localparam logic [7:0] WANTED_RESET = 8'h40;

    // offsets within a frame
    localparam logic [8:0] OFS_CMD   = 9'd3;
    localparam logic [8:0] OFS_LENHI = 9'd4;
    localparam logic [8:0] OFS_LENLO = 9'd5;
    localparam logic [8:0] OFS_BODY  = 9'd6;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // parser phase codes
    localparam logic [2:0] PH_HUNT0 = 3'd0;
    localparam logic [2:0] PH_HUNT1 = 3'd1;
    localparam logic [2:0] PH_HUNT2 = 3'd2;
    localparam logic [2:0] PH_CMD   = 3'd3;
    localparam logic [2:0] PH_LENHI = 3'd4;
    localparam logic [2:0] PH_LENLO = 3'd5;
    localparam logic [2:0] PH_BODY  = 3'd6;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] frame_command;
        logic [2:0] ack_sequence;
        logic       frame_ok;
        logic       is_wanted;
    } t_result;

endpackage

FILE: hw/rtl/fbdf_if.sv
// ----------------------------------------------------------------------------
// fbdf_byte_if / fbdf_result_if
// Valid/ready channels for received bytes and for deframer result beats.
// ----------------------------------------------------------------------------
interface fbdf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fbdf_result_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] frame_command;
    logic [2:0] ack_sequence;
    logic       frame_ok;
    logic       is_wanted;

    modport source (
        output valid, output kind, output data_byte, output frame_command,
        output ack_sequence, output frame_ok, output is_wanted, input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input frame_command,
        input ack_sequence, input frame_ok, input is_wanted, output ready
    );
endinterface

FILE: hw/rtl/fbdf_parser.sv
// ----------------------------------------------------------------------------
// fbdf_parser
// Frame state machine: header hunt, command and length capture, payload
// pass-through, checksum folding and the end of frame report.
// ----------------------------------------------------------------------------
module fbdf_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic [7:0]         i_wanted_command,
    output logic               o_res_valid,
    output fbdf_pkg::t_result  o_res
);
    import fbdf_pkg::*;

    logic [2:0] r_phase,     n_phase;
    logic [8:0] r_offset,    n_offset;
    logic [7:0] r_length,    n_length;
    logic [7:0] r_command,   n_command;
    logic [7:0] r_even_xor,  n_even_xor;
    logic [7:0] r_odd_xor,   n_odd_xor;
    logic [7:0] r_sequence,  n_sequence;
    logic       r_even_ok,   n_even_ok;

    logic [8:0] data_end;
    logic [8:0] ck_pos;
    logic       frame_ok;

    // frame boundaries from the low length byte
    assign data_end = OFS_BODY + {1'b0, r_length};
    assign ck_pos   = data_end + {8'd0, r_length[0]};
    assign frame_ok = r_even_ok && (r_odd_xor == i_byte);

    // next state and result for the beat
    always_comb begin
        n_phase     = r_phase;
        n_offset    = r_offset;
        n_length    = r_length;
        n_command   = r_command;
        n_even_xor  = r_even_xor;
        n_odd_xor   = r_odd_xor;
        n_sequence  = r_sequence;
        n_even_ok   = r_even_ok;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (r_phase)
            PH_HUNT1: begin
                if (i_byte == HDR_BYTE1) begin
                    n_phase = PH_HUNT2;
                end else if (i_byte != HDR_BYTE0) begin
                    n_phase = PH_HUNT0;
                end
            end
            PH_HUNT2: begin
                if (i_byte == HDR_BYTE2) begin
                    n_phase    = PH_CMD;
                    n_offset   = OFS_CMD;
                    n_even_xor = HDR_BYTE0;
                    n_odd_xor  = HDR_BYTE1;
                end else begin
                    n_phase = (i_byte == HDR_BYTE0) ? PH_HUNT1 : PH_HUNT0;
                end
            end
            PH_CMD: begin
                // acknowledge frames are dropped silently
                if (i_byte == CMD_ACK) begin
                    n_phase = PH_HUNT0;
                end else begin
                    n_command = i_byte;
                    n_odd_xor = r_odd_xor ^ i_byte;
                    n_offset  = OFS_LENHI;
                    n_phase   = PH_LENHI;
                end
            end
            PH_LENHI: begin
                n_even_xor = r_even_xor ^ i_byte;
                n_offset   = OFS_LENLO;
                n_phase    = PH_LENLO;
            end
            PH_LENLO: begin
                n_odd_xor  = r_odd_xor ^ i_byte;
                n_length   = i_byte;
                n_sequence = '0;
                n_offset   = OFS_BODY;
                n_phase    = PH_BODY;
            end
            PH_BODY: begin
                if (r_offset < ck_pos) begin
                    // payload and pad bytes fold into the checksums
                    if (r_offset[0]) begin
                        n_odd_xor = r_odd_xor ^ i_byte;
                    end else begin
                        n_even_xor = r_even_xor ^ i_byte;
                    end
                    if (r_offset == data_end - 9'd1) begin
                        n_sequence = i_byte;
                    end else if (r_offset < data_end) begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_DATA;
                        o_res.data_byte     = (i_byte == NUL_BYTE) ? NUL_SUBST : i_byte;
                        o_res.frame_command = r_command;
                    end
                end else if (r_offset == ck_pos) begin
                    n_even_ok = (r_even_xor == i_byte);
                end else begin
                    // second checksum byte closes the frame
                    o_res_valid         = 1'b1;
                    o_res.kind          = KIND_REPORT;
                    o_res.frame_command = r_command;
                    o_res.ack_sequence  = r_sequence[2:0];
                    o_res.frame_ok      = frame_ok;
                    o_res.is_wanted     = frame_ok && (r_command == i_wanted_command);
                    n_phase             = PH_HUNT0;
                end
                n_offset = r_offset + 9'd1;
            end
            default: begin
                n_phase = (i_byte == HDR_BYTE0) ? PH_HUNT1 : PH_HUNT0;
            end
        endcase
    end

    // state update on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT0;
            r_offset   <= '0;
            r_length   <= '0;
            r_command  <= '0;
            r_even_xor <= '0;
            r_odd_xor  <= '0;
            r_sequence <= '0;
            r_even_ok  <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_offset   <= n_offset;
            r_length   <= n_length;
            r_command  <= n_command;
            r_even_xor <= n_even_xor;
            r_odd_xor  <= n_odd_xor;
            r_sequence <= n_sequence;
            r_even_ok  <= n_even_ok;
        end
    end

endmodule

FILE: hw/rtl/fbdf_out_reg.sv
// ----------------------------------------------------------------------------
// fbdf_out_reg
// Result register: holds one result beat until the consumer takes it and
// reports when it can take another.
// ----------------------------------------------------------------------------
module fbdf_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  fbdf_pkg::t_result  i_res,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_free,
    output fbdf_pkg::t_result  o_res
);
    import fbdf_pkg::*;

    logic    r_valid;
    t_result r_res;

    // the slot frees up in the cycle it drains
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: hw/rtl/fbus_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// fbus_frame_deframer_unit
// A result beat is registered and appears in the cycle after its source byte.
// Throughput: one byte per cycle unless the result side stalls; the parser state
// updates in one pass and the result register frees in the cycle it drains.
// Reset: synchronous active low; hunt for the header, wanted command 0x40.
// ----------------------------------------------------------------------------
module fbus_frame_deframer_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    fbdf_byte_if.sink        i_rx,
    fbdf_result_if.source    o_res
);
    import fbdf_pkg::*;

    logic [7:0] r_wanted;
    logic       accept;
    logic       free;
    logic       res_valid;
    t_result    res;
    t_result    res_q;

    // wanted command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted <= WANTED_RESET;
        end else if (i_cfg_wr_en) begin
            r_wanted <= i_cfg_wr_data;
        end
    end

    assign i_rx.ready = free;
    assign accept     = i_rx.valid && free;

    fbdf_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_byte           (i_rx.rx_byte),
        .i_wanted_command (r_wanted),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    fbdf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && res_valid),
        .i_res   (res),
        .i_ready (o_res.ready),
        .o_valid (o_res.valid),
        .o_free  (free),
        .o_res   (res_q)
    );

    // result beat fields
    assign o_res.kind          = res_q.kind;
    assign o_res.data_byte     = res_q.data_byte;
    assign o_res.frame_command = res_q.frame_command;
    assign o_res.ack_sequence  = res_q.ack_sequence;
    assign o_res.frame_ok      = res_q.frame_ok;
    assign o_res.is_wanted     = res_q.is_wanted;

    // checks
    a_report_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == KIND_REPORT) |-> (o_res.data_byte == NUL_BYTE))
        else $error("report beat carries data");

    a_data_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == KIND_DATA) |->
            (!o_res.frame_ok && !o_res.is_wanted && o_res.ack_sequence == 3'd0))
        else $error("payload beat carries report status");

    a_wanted_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_wanted) |-> o_res.frame_ok)
        else $error("wanted flag without checksum match");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_rx.ready)
        else $error("byte accepted while result stalled");

endmodule

FILE: test/fbus_frame_deframer_unit_tb.sv
// ----------------------------------------------------------------------------
// fbus_frame_deframer_unit_tb
// Feeds received bytes into the deframer: a short table of hand-built frames
// (header overlaps, acknowledge drop, zero length, odd length, bad checksum),
// then random frames with random content, noise and cut or corrupted frames.
// Every result beat is checked field by field against the typed-in result or
// a cycle-free deframer model run on each accepted byte. Both handshakes idle
// in random bursts, the result side holds off once for a long stretch, and the
// wanted command is rewritten between phases with the block idle.
// ----------------------------------------------------------------------------
module fbus_frame_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbdf_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 2000;
    localparam t_result NO_RES   = '0;

    typedef enum int {FLAW_NONE, FLAW_CHECKSUM, FLAW_CUT} t_flaw;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       has_res;
        t_result    res;
    } t_dir_row;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    fbdf_byte_if   rx_if ();
    fbdf_result_if res_if ();

    fbus_frame_deframer_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_rx          (rx_if),
        .o_res         (res_if)
    );

    // hand-built frames; fixed results are typed in, the rest come from the model
    t_dir_row directed_rows [27] = '{
        // zero-length frame with the wanted command, good checksums
        '{8'h1E, 1'b0, NO_RES}, '{8'h0C, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h40, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h1E, 1'b0, NO_RES},
        '{8'h4C, 1'b1, '{KIND_REPORT, 8'h00, 8'h40, 3'd0, 1'b1, 1'b1}},
        // overlapping header bytes, then an acknowledge frame that is dropped
        '{8'h1E, 1'b0, NO_RES}, '{8'h1E, 1'b0, NO_RES}, '{8'h0C, 1'b0, NO_RES},
        '{8'h1E, 1'b0, NO_RES}, '{8'h0C, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{CMD_ACK, 1'b0, NO_RES},
        // odd length with pad, extreme bytes, checksum failure
        '{8'h1E, 1'b0, NO_RES}, '{8'h0C, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}, '{8'h03, 1'b0, NO_RES},
        '{8'h00, 1'b1, '{KIND_DATA, NUL_SUBST, 8'hFF, 3'd0, 1'b0, 1'b0}},
        '{8'hFF, 1'b1, '{KIND_DATA, 8'hFF, 8'hFF, 3'd0, 1'b0, 1'b0}},
        '{8'h05, 1'b0, NO_RES}, '{8'hAA, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b1, '{KIND_REPORT, 8'h00, 8'hFF, 3'd5, 1'b0, 1'b0}}
    };

    // deframer model state
    logic [2:0] hunt_phase;
    logic [8:0] frame_ofs;
    logic [7:0] body_len;
    logic [7:0] frame_cmd;
    logic [7:0] xor_even;
    logic [7:0] xor_odd;
    logic [7:0] seq_byte;
    logic       even_ck_match;
    logic [7:0] wanted_cmd;

    t_result frame_results_q [$];
    int      bad_beats    = 0;
    int      quiet_cycles = 0;
    int      frame_bytes  = 0;
    int      hold_len     = 0;
    bit      calm         = 1'b0;

    // expectation typed in for the beat currently offered
    logic    row_has_res;
    t_result row_res;

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // model: one received byte in, at most one result out
    task automatic deframe_byte(input logic [7:0] b, output logic made, output t_result r);
        logic [8:0] data_end;
        logic [8:0] ck_pos;
        logic       ok;
        made = 1'b0;
        r    = NO_RES;
        case (hunt_phase)
            PH_HUNT1: begin
                if (b == HDR_BYTE1) hunt_phase = PH_HUNT2;
                else if (b != HDR_BYTE0) hunt_phase = PH_HUNT0;
            end
            PH_HUNT2: begin
                if (b == HDR_BYTE2) begin
                    hunt_phase = PH_CMD;
                    frame_ofs  = OFS_CMD;
                    xor_even   = HDR_BYTE0;
                    xor_odd    = HDR_BYTE1;
                end else begin
                    hunt_phase = (b == HDR_BYTE0) ? PH_HUNT1 : PH_HUNT0;
                end
            end
            PH_CMD: begin
                if (b == CMD_ACK) begin
                    hunt_phase = PH_HUNT0;
                end else begin
                    frame_cmd  = b;
                    xor_odd    = xor_odd ^ b;
                    frame_ofs  = OFS_LENHI;
                    hunt_phase = PH_LENHI;
                end
            end
            PH_LENHI: begin
                xor_even   = xor_even ^ b;
                frame_ofs  = OFS_LENLO;
                hunt_phase = PH_LENLO;
            end
            PH_LENLO: begin
                xor_odd    = xor_odd ^ b;
                body_len   = b;
                seq_byte   = 8'h00;
                frame_ofs  = OFS_BODY;
                hunt_phase = PH_BODY;
            end
            PH_BODY: begin
                data_end = OFS_BODY + 9'(body_len);
                ck_pos   = data_end + 9'(body_len[0]);
                if (frame_ofs < ck_pos) begin
                    // payload and pad fold into the checksum of their parity
                    if (frame_ofs[0]) xor_odd = xor_odd ^ b;
                    else xor_even = xor_even ^ b;
                    if (frame_ofs == data_end - 9'd1) begin
                        seq_byte = b;
                    end else if (frame_ofs < data_end) begin
                        made = 1'b1;
                        r = '{KIND_DATA, (b == NUL_BYTE) ? NUL_SUBST : b, frame_cmd,
                              3'd0, 1'b0, 1'b0};
                    end
                end else if (frame_ofs == ck_pos) begin
                    even_ck_match = (xor_even == b);
                end else begin
                    ok   = even_ck_match && (xor_odd == b);
                    made = 1'b1;
                    r = '{KIND_REPORT, 8'h00, frame_cmd, seq_byte[2:0], ok,
                          ok && (frame_cmd == wanted_cmd)};
                    hunt_phase = PH_HUNT0;
                end
                frame_ofs = frame_ofs + 9'd1;
            end
            default: hunt_phase = (b == HDR_BYTE0) ? PH_HUNT1 : PH_HUNT0;
        endcase
    endtask

    task automatic report_mismatch(input string why, input t_result want, input t_result got);
        bad_beats++;
        if (bad_beats <= 10) begin
            $display("%0t mismatch (%s): expected kind=%0d data=%02h cmd=%02h seq=%0d ok=%0d wanted=%0d",
                     $time, why, want.kind, want.data_byte, want.frame_command,
                     want.ack_sequence, want.frame_ok, want.is_wanted);
            $display("    actual kind=%0d data=%02h cmd=%02h seq=%0d ok=%0d wanted=%0d",
                     got.kind, got.data_byte, got.frame_command, got.ack_sequence,
                     got.frame_ok, got.is_wanted);
        end
    endtask

    // run the model on accepted bytes, check accepted result beats
    always @(posedge clk) begin : scoreboard
        logic    made;
        t_result pred;
        t_result got;
        t_result want;
        if (rst_n && rx_if.valid && rx_if.ready) begin
            deframe_byte(rx_if.rx_byte, made, pred);
            if (row_has_res) frame_results_q.push_back(row_res);
            else if (made) frame_results_q.push_back(pred);
        end
        if (rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.kind, res_if.data_byte, res_if.frame_command,
                    res_if.ack_sequence, res_if.frame_ok, res_if.is_wanted};
            if (frame_results_q.size() == 0) begin
                report_mismatch("no beat expected", NO_RES, got);
            end else begin
                want = frame_results_q.pop_front();
                if (got !== want) report_mismatch("field differs", want, got);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk) begin : watchdog
        if (!rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin : result_sink
        res_if.ready = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_len > 0) begin
                res_if.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // offer one byte, with an optional gap before it, and wait for the beat
    task automatic send_byte(input logic [7:0] b, input logic has_res, input t_result res);
        if (!calm && $urandom_range(0, 4) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        row_has_res   <= has_res;
        row_res       <= res;
        @(posedge clk);
        while (!rx_if.ready) @(posedge clk);
    endtask

    // stop offering and let every outstanding result drain
    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (frame_results_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_wanted(input logic [7:0] v);
        wait_idle();
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        wanted_cmd  = v;
    endtask

    // build a frame with correct checksums, then damage it if asked
    task automatic send_frame(input logic [7:0] cmd, input int len, input t_flaw flaw);
        logic [7:0] fr [$];
        logic [7:0] even_ck;
        logic [7:0] odd_ck;
        int         at;
        fr.push_back(HDR_BYTE0); fr.push_back(HDR_BYTE1); fr.push_back(HDR_BYTE2);
        fr.push_back(cmd); fr.push_back(8'($urandom)); fr.push_back(8'(len));
        repeat (len) fr.push_back(($urandom_range(0, 7) == 0) ? NUL_BYTE : 8'($urandom));
        if (len % 2 == 1) fr.push_back(8'($urandom));
        even_ck = 8'h00;
        odd_ck  = 8'h00;
        foreach (fr[i]) begin
            if (i % 2 == 1) odd_ck = odd_ck ^ fr[i];
            else even_ck = even_ck ^ fr[i];
        end
        fr.push_back(even_ck);
        fr.push_back(odd_ck);
        case (flaw)
            FLAW_CHECKSUM: begin
                at = fr.size() - 1 - $urandom_range(0, 1);
                fr[at] = fr[at] ^ (8'h01 << $urandom_range(0, 7));
            end
            FLAW_CUT: begin
                at = $urandom_range(3, fr.size() - 2);
                while (fr.size() > at) void'(fr.pop_back());
            end
            default: ;
        endcase
        foreach (fr[i]) send_byte(fr[i], 1'b0, NO_RES);
        frame_bytes += fr.size();
    endtask

    // mostly well-formed frames with random content, some noise and damage
    task automatic random_traffic(input int n_bytes);
        int         goal;
        int         len;
        int         r;
        logic [7:0] cmd;
        logic [7:0] noise;
        t_flaw      flaw;
        goal = frame_bytes + n_bytes;
        while (frame_bytes < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 4))
                        0: noise = HDR_BYTE0;
                        1: noise = HDR_BYTE1;
                        2: noise = HDR_BYTE2;
                        default: noise = 8'($urandom);
                    endcase
                    send_byte(noise, 1'b0, NO_RES);
                end
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: cmd = wanted_cmd;
                    4: cmd = CMD_ACK;
                    5: cmd = 8'h00;
                    6: cmd = 8'hFF;
                    default: cmd = 8'($urandom);
                endcase
                r = $urandom_range(0, 49);
                if (r == 0) len = $urandom_range(200, 255);
                else if (r < 8) len = $urandom_range(13, 64);
                else len = $urandom_range(0, 12);
                r = $urandom_range(0, 23);
                if (r < 3) flaw = FLAW_CHECKSUM;
                else if (r < 5) flaw = FLAW_CUT;
                else flaw = FLAW_NONE;
                send_frame(cmd, len, flaw);
            end
        end
    endtask

    // main sequence
    initial begin : stimulus
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 8'h00;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        row_has_res   = 1'b0;
        row_res       = NO_RES;
        hunt_phase    = PH_HUNT0;
        frame_ofs     = '0;
        body_len      = 8'h00;
        frame_cmd     = 8'h00;
        xor_even      = 8'h00;
        xor_odd       = 8'h00;
        seq_byte      = 8'h00;
        even_ck_match = 1'b0;
        wanted_cmd    = WANTED_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames with the reset wanted command
        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx_byte, directed_rows[i].has_res, directed_rows[i].res);

        set_wanted(8'h00);
        random_traffic(300);

        // longest frame, wanted command at its top value
        set_wanted(8'hFF);
        send_frame(8'hFF, 255, FLAW_NONE);
        random_traffic(150);

        // result side holds off while a long frame keeps coming
        wait_idle();
        hold_len = 80;
        send_frame(wanted_cmd, 60, FLAW_NONE);
        wait_idle();

        set_wanted(8'($urandom));
        random_traffic(300);

        // last stretch without any idling
        set_wanted(8'($urandom));
        calm = 1'b1;
        random_traffic(200);

        wait_idle();
        if (bad_beats == 0 && frame_results_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
